// ----- hdl/fw2hw_pkg.sv -----
// ----------------------------------------------------------------------------
// fw2hw_pkg: shared types and constants
// Byte codes, queue sizing and the result record of the fullwidth to halfwidth
// UTF-8 converter.
// ----------------------------------------------------------------------------
package fw2hw_pkg;

  // lead byte thresholds for character length
  localparam logic [7:0] LEAD_2B_MIN = 8'hC0;
  localparam logic [7:0] LEAD_3B_MIN = 8'hE0;
  localparam logic [7:0] LEAD_4B_MIN = 8'hF0;

  // fullwidth sequences
  localparam logic [7:0] CJK_LEAD    = 8'hE3;
  localparam logic [7:0] CJK_SPACE   = 8'h80;
  localparam logic [7:0] FW_LEAD     = 8'hEF;
  localparam logic [7:0] FW_HI_PAGE  = 8'hBD;
  localparam logic [7:0] FW_LO_PAGE  = 8'hBC;
  localparam logic [7:0] FW_HI_OFS   = 8'h20;
  localparam logic [7:0] FW_LO_OFS   = 8'h60;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // most result bytes one input byte can release
  localparam int MAX_RESULTS = 3;
  // default output queue depth
  localparam int OQ_DEPTH    = 8;

  // one result byte
  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } entry_t;

  // results of one accepted input byte, entry 0 goes out first
  typedef struct packed {
    logic [1:0]   cnt;
    entry_t [2:0] ent;
  } emit_t;

endpackage

// ----- hdl/fw2hw_byte_if.sv -----
// ----------------------------------------------------------------------------
// fw2hw_byte_if: byte stream channel
// Valid/ready channel carrying one byte and an end-of-text flag.
// ----------------------------------------------------------------------------
interface fw2hw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;
  logic       last;

  modport source (output valid, output octet, output last, input ready);
  modport sink   (input valid, input octet, input last, output ready);
endinterface

// ----- hdl/fullwidth_to_halfwidth_utf8_unit.sv -----
// ----------------------------------------------------------------------------
// fullwidth_to_halfwidth_utf8_unit: fullwidth to halfwidth UTF-8 converter
// Converts fullwidth ASCII forms and the ideographic space in a UTF-8 byte
// stream to their plain ASCII bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the text one byte per request, last set on its final byte.
//   out_ch carries the converted text, last set on its final byte.
//   A byte is taken in every cycle while in_ch.ready is high. Bytes of 1-,
//   2- and 4-byte characters go into the output queue as they are taken. A
//   3-byte character is held inside until its third byte arrives; its one
//   or three result bytes then go into the output queue together.
//   Throughput is one byte per cycle on each side, set by the one-read
//   port of the output queue; in_ch.ready drops only when the queue has
//   fewer than three free entries, which happens when out_ch stalls.
//   A stalled receiver holds the head byte; no result is lost.
//   A character cut short by last is flushed raw and ends the text.
//   Synchronous reset (rst_n low) clears the character state and empties
//   the queue; out_ch.valid is low after reset.
// ----------------------------------------------------------------------------
module fullwidth_to_halfwidth_utf8_unit #(
  parameter int OQ_DEPTH = fw2hw_pkg::OQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  fw2hw_byte_if.sink   in_ch,
  fw2hw_byte_if.source out_ch
);

  fw2hw_pkg::emit_t emit;
  logic             room;
  logic             take;

  assign in_ch.ready = room;
  assign take        = in_ch.valid && room;

  // character tracking and mapping
  fw2hw_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .octet (in_ch.octet),
    .last  (in_ch.last),
    .emit  (emit)
  );

  // result buffering
  fw2hw_oq #(
    .DEPTH (OQ_DEPTH)
  ) u_oq (
    .clk    (clk),
    .rst_n  (rst_n),
    .emit   (emit),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ----- hdl/fw2hw_conv.sv -----
// ----------------------------------------------------------------------------
// fw2hw_conv: character tracker and mapper
// Follows UTF-8 character boundaries, holds 3-byte characters until complete
// and maps fullwidth forms to their halfwidth bytes.
// ----------------------------------------------------------------------------
module fw2hw_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         octet,
  input  logic               last,
  output fw2hw_pkg::emit_t   emit
);

  logic [1:0] skip_left_r,   skip_left_nxt;
  logic [1:0] held_count_r,  held_count_nxt;
  logic [7:0] held_lead_r,   held_lead_nxt;
  logic [7:0] held_second_r, held_second_nxt;

  // state update and result bytes for the byte in the request
  always_comb begin
    skip_left_nxt   = skip_left_r;
    held_count_nxt  = held_count_r;
    held_lead_nxt   = held_lead_r;
    held_second_nxt = held_second_r;
    emit            = '0;
    if (take) begin
      priority if (held_count_r == 2'd1) begin
        // second byte of a held character
        if (last) begin
          emit.cnt    = 2'd2;
          emit.ent[0] = '{octet: held_lead_r, last: 1'b0};
          emit.ent[1] = '{octet: octet, last: 1'b1};
          skip_left_nxt   = '0;
          held_count_nxt  = '0;
          held_lead_nxt   = '0;
          held_second_nxt = '0;
        end else begin
          held_second_nxt = octet;
          held_count_nxt  = 2'd2;
        end
      end else if (held_count_r == 2'd2) begin
        // third byte completes the character
        priority if (held_lead_r == fw2hw_pkg::CJK_LEAD &&
                     held_second_r == fw2hw_pkg::CJK_SPACE &&
                     octet == fw2hw_pkg::CJK_SPACE) begin
          emit.cnt    = 2'd1;
          emit.ent[0] = '{octet: fw2hw_pkg::ASCII_SPACE, last: last};
        end else if (held_lead_r == fw2hw_pkg::FW_LEAD &&
                     held_second_r == fw2hw_pkg::FW_HI_PAGE) begin
          emit.cnt    = 2'd1;
          emit.ent[0] = '{octet: octet - fw2hw_pkg::FW_HI_OFS, last: last};
        end else if (held_lead_r == fw2hw_pkg::FW_LEAD &&
                     held_second_r == fw2hw_pkg::FW_LO_PAGE) begin
          emit.cnt    = 2'd1;
          emit.ent[0] = '{octet: octet - fw2hw_pkg::FW_LO_OFS, last: last};
        end else begin
          emit.cnt    = 2'd3;
          emit.ent[0] = '{octet: held_lead_r, last: 1'b0};
          emit.ent[1] = '{octet: held_second_r, last: 1'b0};
          emit.ent[2] = '{octet: octet, last: last};
        end
        held_count_nxt  = '0;
        held_lead_nxt   = '0;
        held_second_nxt = '0;
        if (last) begin
          skip_left_nxt = '0;
        end
      end else if (skip_left_r != 2'd0) begin
        // continuation of a 2- or 4-byte character
        emit.cnt      = 2'd1;
        emit.ent[0]   = '{octet: octet, last: last};
        skip_left_nxt = skip_left_r - 2'd1;
        if (last) begin
          skip_left_nxt   = '0;
          held_count_nxt  = '0;
          held_lead_nxt   = '0;
          held_second_nxt = '0;
        end
      end else begin
        // lead byte of a new character
        held_count_nxt = '0;
        if (octet >= fw2hw_pkg::LEAD_3B_MIN && octet < fw2hw_pkg::LEAD_4B_MIN) begin
          if (last) begin
            emit.cnt        = 2'd1;
            emit.ent[0]     = '{octet: octet, last: 1'b1};
            held_lead_nxt   = '0;
            held_second_nxt = '0;
          end else begin
            held_lead_nxt  = octet;
            held_count_nxt = 2'd1;
          end
        end else begin
          emit.cnt    = 2'd1;
          emit.ent[0] = '{octet: octet, last: last};
          priority if (octet < fw2hw_pkg::LEAD_2B_MIN) begin
            skip_left_nxt = 2'd0;
          end else if (octet < fw2hw_pkg::LEAD_3B_MIN) begin
            skip_left_nxt = 2'd1;
          end else begin
            skip_left_nxt = 2'd3;
          end
          if (last) begin
            skip_left_nxt   = '0;
            held_lead_nxt   = '0;
            held_second_nxt = '0;
          end
        end
      end
    end
  end

  // character state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_left_r   <= '0;
      held_count_r  <= '0;
      held_lead_r   <= '0;
      held_second_r <= '0;
    end else begin
      skip_left_r   <= skip_left_nxt;
      held_count_r  <= held_count_nxt;
      held_lead_r   <= held_lead_nxt;
      held_second_r <= held_second_nxt;
    end
  end

  // a held character never overlaps a pass-through character
  a_hold_excl_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (held_count_r != 2'd0) |-> (skip_left_r == 2'd0))
    else $error("held character while skipping");

  // at most two bytes are ever held
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r != 2'd3)
    else $error("held count out of range");

  // an end-of-text byte always releases a result and leaves no state behind
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |-> (emit.cnt != 2'd0) ##1
      (held_count_r == 2'd0 && skip_left_r == 2'd0))
    else $error("end of text left state behind");

endmodule

// ----- hdl/fw2hw_oq.sv -----
// ----------------------------------------------------------------------------
// fw2hw_oq: output queue
// Small register queue that takes up to three result bytes a cycle and hands
// out one a cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module fw2hw_oq #(
  parameter int DEPTH = fw2hw_pkg::OQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fw2hw_pkg::emit_t    emit,
  output logic                room,
  fw2hw_byte_if.source        out_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MR = fw2hw_pkg::MAX_RESULTS;

  fw2hw_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic [PW-1:0] wr_idx [MR];
  logic          pop;
  logic [PW:0]   sum;

  // write slots with wrap
  always_comb begin
    for (int i = 0; i < MR; i++) begin
      sum = {1'b0, wr_ptr_r} + (PW+1)'(i);
      if (sum >= (PW+1)'(DEPTH)) begin
        sum = sum - (PW+1)'(DEPTH);
      end
      wr_idx[i] = sum[PW-1:0];
    end
    sum = {1'b0, wr_ptr_r} + (PW+1)'(emit.cnt);
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    wr_ptr_nxt = sum[PW-1:0];
  end

  assign pop        = out_ch.valid && out_ch.ready;
  assign rd_ptr_nxt = !pop ? rd_ptr_r :
                      (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
  assign count_nxt  = count_r + CW'(emit.cnt) - CW'(pop);

  // accept only when a worst-case burst fits
  assign room = (count_r <= CW'(DEPTH - MR));

  assign out_ch.valid = (count_r != '0);
  assign out_ch.octet = mem[rd_ptr_r].octet;
  assign out_ch.last  = mem[rd_ptr_r].last;

  // storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MR; i++) begin
      if (2'(i) < emit.cnt) begin
        mem[wr_idx[i]] <= emit.ent[i];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // a push never overruns the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.cnt != 2'd0) |-> ((CW+1)'(count_r) + (CW+1)'(emit.cnt) <= (CW+1)'(DEPTH)))
    else $error("output queue overflow");

  // fill level stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("output queue count out of range");

  // a lone pop drops the fill level by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit.cnt == 2'd0) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("output queue count slip on pop");

endmodule

// ----- sim/fw2hw_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fw2hw_checker: result checker for the fullwidth to halfwidth converter
// Watches both byte channels, predicts the converted text from every accepted
// input request and compares each output request, in order, field by field.
// ----------------------------------------------------------------------------
module fw2hw_checker (
  input  logic  clk,
  input  logic  rst_n,
  fw2hw_byte_if in_ch,
  fw2hw_byte_if out_ch,
  output int    err_count,
  output int    pending
);

  // converted bytes still to come out of the block
  fw2hw_pkg::entry_t converted_q [$];
  fw2hw_pkg::entry_t head;

  // character state of the prediction
  logic [1:0] run_left;
  logic [1:0] held_n;
  logic [7:0] held_b0;
  logic [7:0] held_b1;

  function void clear_char();
    run_left = '0;
    held_n   = '0;
    held_b0  = '0;
    held_b1  = '0;
  endfunction

  function void emit(input logic [7:0] b, input logic l);
    fw2hw_pkg::entry_t e;
    e.octet = b;
    e.last  = l;
    converted_q = {converted_q, e};
  endfunction

  // one input byte in, zero to three converted bytes out
  function void convert_byte(input logic [7:0] b, input logic l);
    case (held_n)
      2'd1: begin
        if (l) begin
          // text ends on the second byte of a 3-byte character
          emit(held_b0, 1'b0);
          emit(b, 1'b1);
          clear_char();
        end else begin
          held_b1 = b;
          held_n  = 2'd2;
        end
      end
      2'd2: begin
        if (held_b0 == fw2hw_pkg::CJK_LEAD && held_b1 == fw2hw_pkg::CJK_SPACE &&
            b == fw2hw_pkg::CJK_SPACE) begin
          emit(fw2hw_pkg::ASCII_SPACE, l);
        end else if (held_b0 == fw2hw_pkg::FW_LEAD &&
                     held_b1 == fw2hw_pkg::FW_HI_PAGE) begin
          emit(8'(b - fw2hw_pkg::FW_HI_OFS), l);
        end else if (held_b0 == fw2hw_pkg::FW_LEAD &&
                     held_b1 == fw2hw_pkg::FW_LO_PAGE) begin
          emit(8'(b - fw2hw_pkg::FW_LO_OFS), l);
        end else begin
          emit(held_b0, 1'b0);
          emit(held_b1, 1'b0);
          emit(b, l);
        end
        clear_char();
      end
      default: begin
        // a held count of three cannot arise and counts as nothing held
        held_n = 2'd0;
        if (run_left != 2'd0) begin
          emit(b, l);
          run_left = run_left - 2'd1;
          if (l) clear_char();
        end else if (b >= fw2hw_pkg::LEAD_3B_MIN && b < fw2hw_pkg::LEAD_4B_MIN) begin
          if (l) begin
            emit(b, 1'b1);
            clear_char();
          end else begin
            held_b0 = b;
            held_n  = 2'd1;
          end
        end else begin
          emit(b, l);
          if (b < fw2hw_pkg::LEAD_2B_MIN)      run_left = 2'd0;
          else if (b < fw2hw_pkg::LEAD_3B_MIN) run_left = 2'd1;
          else                                 run_left = 2'd3;
          if (l) clear_char();
        end
      end
    endcase
  endfunction

  function void report_mismatch(input logic [7:0] exp_b, input logic exp_l,
                                input logic has_exp);
    err_count++;
    if (err_count <= 10) begin
      if (has_exp)
        $display("%0t: out byte expected %02h last %0b, got %02h last %0b",
                 $realtime, exp_b, exp_l, out_ch.octet, out_ch.last);
      else
        $display("%0t: out byte %02h last %0b with nothing expected",
                 $realtime, out_ch.octet, out_ch.last);
    end
  endfunction

  // outputs are checked before the input of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      converted_q.delete();
      clear_char();
      err_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (converted_q.size() == 0) begin
          report_mismatch(8'h00, 1'b0, 1'b0);
        end else begin
          head = converted_q.pop_front();
          if (out_ch.octet !== head.octet || out_ch.last !== head.last)
            report_mismatch(head.octet, head.last, 1'b1);
        end
      end
      if (in_ch.valid && in_ch.ready)
        convert_byte(in_ch.octet, in_ch.last);
    end
    pending = converted_q.size();
  end

endmodule

// ----- sim/tb_fullwidth_to_halfwidth_utf8_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fullwidth_to_halfwidth_utf8_unit: converter testbench
// Sends directed and random UTF-8 texts through the converter under several
// sender and receiver idle rates, with one long receiver hold-off; the checker
// beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module tb_fullwidth_to_halfwidth_utf8_unit;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fw2hw_byte_if in_if ();
  fw2hw_byte_if out_if ();

  int err_count;
  int pending;

  // pacing shared with the receiver
  int send_idle  = 0;
  int stall_pct  = 0;
  int hold_asks  = 0;
  int hold_done  = 0;
  int hold_left  = 0;

  int sent_items = 0;
  int idle_tab  [4] = '{0, 77, 0, 36};
  int stall_tab [4] = '{0, 0, 77, 36};

  logic [7:0] text_q [$];

  fullwidth_to_halfwidth_utf8_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  fw2hw_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .err_count (err_count),
    .pending   (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("fullwidth_to_halfwidth_utf8_unit: mismatch");
    $finish;
  end

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // fill text_q with random characters, sometimes cutting the final one short
  task automatic build_text(input int n_chars);
    int k;
    int start;
    int len;
    int keep;
    text_q.delete();
    start = 0;
    for (k = 0; k < n_chars; k++) begin
      start = text_q.size();
      case ($urandom_range(9))
        0, 1: text_q = {text_q, 8'($urandom_range(8'h7F))};
        2: begin
          text_q = {text_q, 8'hC0 | 8'($urandom_range(31))};
          text_q = {text_q, cont_byte()};
        end
        3: text_q = {text_q, fw2hw_pkg::CJK_LEAD, fw2hw_pkg::CJK_SPACE,
                     fw2hw_pkg::CJK_SPACE};
        4: text_q = {text_q, fw2hw_pkg::FW_LEAD, fw2hw_pkg::FW_HI_PAGE,
                     cont_byte()};
        5: text_q = {text_q, fw2hw_pkg::FW_LEAD, fw2hw_pkg::FW_LO_PAGE,
                     cont_byte()};
        6: begin
          text_q = {text_q, 8'hE0 | 8'($urandom_range(15))};
          text_q = {text_q, cont_byte()};
          text_q = {text_q, cont_byte()};
        end
        7: begin
          text_q = {text_q, 8'hF0 | 8'($urandom_range(15))};
          text_q = {text_q, cont_byte()};
          text_q = {text_q, cont_byte()};
          text_q = {text_q, cont_byte()};
        end
        8: text_q = {text_q, 8'($urandom_range(255))};
        default: begin
          // fullwidth page with any third byte, wrapping the subtraction
          text_q = {text_q, fw2hw_pkg::FW_LEAD};
          text_q = {text_q, $urandom_range(1) ? fw2hw_pkg::FW_HI_PAGE
                                              : fw2hw_pkg::FW_LO_PAGE};
          text_q = {text_q, 8'($urandom_range(255))};
        end
      endcase
    end
    len = text_q.size() - start;
    if ($urandom_range(3) == 0 && len > 1) begin
      keep = $urandom_range(len - 1, 1);
      repeat (len - keep) void'(text_q.pop_back());
    end
  endtask

  // send text_q, last set on its final byte; entered and left at a falling edge
  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
      in_if.valid <= 1'b1;
      in_if.octet <= text_q[i];
      in_if.last  <= (i == text_q.size() - 1);
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      @(negedge clk);
      sent_items++;
    end
  endtask

  initial begin
    int ph;
    int phase_end;
    in_if.valid = 1'b0;
    in_if.octet = 8'h00;
    in_if.last  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ascii extremes, lone continuation, every length and mapping
    text_q = '{8'h00, 8'h7F, 8'hBF, 8'hC0, 8'h80, 8'hE3, 8'h80, 8'h80,
               8'hEF, 8'hBD, 8'h81, 8'hEF, 8'hBC, 8'h10, 8'hE0, 8'hA0, 8'h80,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF};
    send_text();
    // text ending after a 3-byte lead
    text_q = '{8'hE3};
    send_text();
    // text ending after two bytes of a 3-byte character
    text_q = '{8'hEF, 8'hBD};
    send_text();
    // fullwidth form completed on the final byte, wrapping
    text_q = '{8'hEF, 8'hBC, 8'h41};
    send_text();

    // random phases of sender and receiver idling
    for (ph = 0; ph < 4; ph++) begin
      send_idle = idle_tab[ph];
      stall_pct = stall_tab[ph];
      phase_end = sent_items + 56;
      if (ph == 0) begin
        // long receiver hold-off while a dense text keeps coming
        hold_asks++;
        build_text(20);
        send_text();
      end
      while (sent_items < phase_end) begin
        build_text($urandom_range(8, 1));
        send_text();
      end
    end
    in_if.valid <= 1'b0;

    // drain, then a short settle for stray output
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0 && pending == 0)
      $display("fullwidth_to_halfwidth_utf8_unit: match");
    else
      $display("fullwidth_to_halfwidth_utf8_unit: mismatch");
    $finish;
  end

endmodule
